// ===== src/aaq_pkg.sv =====
// package for the axis-angle to quaternion core: stage types and constants
package aaq_pkg;

	localparam int ATAN_ENTRIES = 30;
	localparam int SQRT_STEPS   = 32;
	localparam int QBITS        = 17;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

	// floor(atan(2^-i) * 2^30)
	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] v;
		case (i)
			0: v = 36'sd843314856;
			1: v = 36'sd497837829;
			2: v = 36'sd263043836;
			3: v = 36'sd133525158;
			4: v = 36'sd67021686;
			5: v = 36'sd33543515;
			6: v = 36'sd16775850;
			7: v = 36'sd8388437;
			8: v = 36'sd4194282;
			9: v = 36'sd2097149;
			10: v = 36'sd1048575;
			11: v = 36'sd524287;
			12: v = 36'sd262143;
			13: v = 36'sd131071;
			14: v = 36'sd65535;
			15: v = 36'sd32767;
			16: v = 36'sd16383;
			17: v = 36'sd8191;
			18: v = 36'sd4095;
			19: v = 36'sd2047;
			20: v = 36'sd1023;
			21: v = 36'sd511;
			22: v = 36'sd255;
			23: v = 36'sd127;
			24: v = 36'sd63;
			25: v = 36'sd31;
			26: v = 36'sd15;
			27: v = 36'sd7;
			28: v = 36'sd3;
			29: v = 36'sd1;
			default: v = 36'sd0;
		endcase
		return v;
	endfunction

	// cordic and root stage contents
	typedef struct packed {
		logic               vld;
		logic               zero;
		logic               flip;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [35:0] cx;
		logic signed [35:0] cy;
		logic signed [35:0] z;
		logic [63:0]        rem;
		logic [63:0]        res;
	} core_t;

	// product stage contents
	typedef struct packed {
		logic               vld;
		logic               zero;
		logic signed [15:0] w;
		logic signed [51:0] px;
		logic signed [51:0] py;
		logic signed [51:0] pz;
		logic [32:0]        r;
	} mul_t;

	// one divider lane
	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [52:0]       rem;
		logic [QBITS-1:0]  q;
	} lane_t;

	typedef struct packed {
		logic               vld;
		logic               zero;
		logic signed [15:0] w;
		logic [33:0]        d;
		lane_t [2:0]        ln;
	} div_t;

endpackage

// ===== src/axis_angle_to_quaternion_core.sv =====
// axis-angle to unit quaternion core: cordic, square root and divider pipeline
// throughput: one item per cycle, busy is always low; the pipeline depth is
// set by the 32 root steps followed by the 17-bit quotient divider
// the receiver cannot stall: each result shows for one cycle with done high
// reset (arst_n low) clears all valid bits at once; payload is not reset
module axis_angle_to_quaternion_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	output logic               done,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	output logic               axis_zero
);
	import aaq_pkg::*;

	// steps beyond the table size are treated as the full table
	localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

	core_t cor_s [0:SQRT_STEPS];
	core_t cor_in;
	mul_t  mul_s;
	div_t  div_s [0:QBITS];

	// no back pressure anywhere, so an item may enter every cycle
	assign busy = 1'b0;

	// entry: half angle range reduction and squared axis length
	logic signed [35:0] z_in;
	logic [31:0]        len2;
	always_comb begin
		z_in = {{3{angle[15]}}, angle, 17'b0};
		cor_in      = '0;
		cor_in.vld  = start;
		cor_in.ax   = axis_x;
		cor_in.ay   = axis_y;
		cor_in.az   = axis_z;
		cor_in.cx   = GAIN_Q30;
		cor_in.cy   = '0;
		cor_in.flip = 1'b0;
		if (z_in > HALF_PI_Q30) begin
			cor_in.z    = z_in - PI_Q30;
			cor_in.flip = 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			cor_in.z    = z_in + PI_Q30;
			cor_in.flip = 1'b1;
		end else begin
			cor_in.z = z_in;
		end
		len2 = (32'(axis_x) * 32'(axis_x)) + (32'(axis_y) * 32'(axis_y))
			+ (32'(axis_z) * 32'(axis_z));
		cor_in.zero = (len2 == 32'd0);
		cor_in.rem  = {len2, 32'b0};
		cor_in.res  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_s[0].vld <= 1'b0;
		end else begin
			cor_s[0] <= cor_in;
		end
	end

	// each stage does one root step and, while steps remain, one cordic step
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_core
		localparam logic [63:0] SBIT = 64'd1 << (62 - 2 * k);
		core_t       nxt;
		logic [63:0] trial;
		always_comb begin
			nxt   = cor_s[k];
			trial = cor_s[k].res + SBIT;
			if (cor_s[k].rem >= trial) begin
				nxt.rem = cor_s[k].rem - trial;
				nxt.res = (cor_s[k].res >> 1) + SBIT;
			end else begin
				nxt.res = cor_s[k].res >> 1;
			end
			if (k < STEPS) begin
				if (!cor_s[k].z[35]) begin
					nxt.cx = cor_s[k].cx - (cor_s[k].cy >>> k);
					nxt.cy = cor_s[k].cy + (cor_s[k].cx >>> k);
					nxt.z  = cor_s[k].z - atan_q30(k);
				end else begin
					nxt.cx = cor_s[k].cx + (cor_s[k].cy >>> k);
					nxt.cy = cor_s[k].cy - (cor_s[k].cx >>> k);
					nxt.z  = cor_s[k].z + atan_q30(k);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_s[k+1].vld <= 1'b0;
			end else begin
				cor_s[k+1] <= nxt;
			end
		end
	end

	// quadrant fix, cosine rounding to q1.14 and axis times sine products
	core_t              cl;
	logic signed [35:0] cxf, cyf;
	logic [35:0]        cmag;
	logic [36:0]        cq;
	logic signed [15:0] w_nxt;
	always_comb begin
		cl   = cor_s[SQRT_STEPS];
		cxf  = cl.flip ? -cl.cx : cl.cx;
		cyf  = cl.flip ? -cl.cy : cl.cy;
		cmag = cxf[35] ? 36'(-cxf) : 36'(cxf);
		cq   = 37'(({1'b0, cmag, 1'b0} + 38'd65536) >> 17);
		if (cxf[35]) begin
			w_nxt = (cq > 37'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, cq[15:0]}));
		end else begin
			w_nxt = (cq > 37'd32767) ? 16'sd32767 : 16'(cq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s.vld <= 1'b0;
		end else begin
			mul_s.vld  <= cl.vld;
			mul_s.zero <= cl.zero;
			mul_s.w    <= w_nxt;
			mul_s.px   <= 52'(cl.ax) * 52'(cyf);
			mul_s.py   <= 52'(cl.ay) * 52'(cyf);
			mul_s.pz   <= 52'(cl.az) * 52'(cyf);
			mul_s.r    <= cl.res[32:0];
		end
	end

	// divider setup: rounding folded in as (2|p| + r) / (2r)
	div_t dv_in;
	logic signed [51:0] prod [0:2];
	always_comb begin
		prod[0] = mul_s.px;
		prod[1] = mul_s.py;
		prod[2] = mul_s.pz;
		dv_in      = '0;
		dv_in.vld  = mul_s.vld;
		dv_in.zero = mul_s.zero;
		dv_in.w    = mul_s.w;
		dv_in.d    = {mul_s.r, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dv_in.ln[i].neg = prod[i][51];
			dv_in.ln[i].rem = {(prod[i][51] ? 52'(-prod[i]) : 52'(prod[i])), 1'b0}
				+ 53'(mul_s.r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].vld <= 1'b0;
		end else begin
			div_s[0] <= dv_in;
		end
	end

	// restoring division, one quotient bit per stage, msb first;
	// the first stage also flags quotients too large for the result
	for (genvar t = 0; t < QBITS; t++) begin : g_div
		localparam int SH = QBITS - 1 - t;
		div_t        nxt;
		logic [52:0] dsh;
		always_comb begin
			nxt = div_s[t];
			dsh = 53'(div_s[t].d) << SH;
			for (int i = 0; i < 3; i++) begin
				if (t == 0) begin
					nxt.ln[i].ovf = (div_s[t].ln[i].rem >= (53'(div_s[t].d) << QBITS));
				end
				if (div_s[t].ln[i].rem >= dsh) begin
					nxt.ln[i].rem   = div_s[t].ln[i].rem - dsh;
					nxt.ln[i].q[SH] = 1'b1;
				end else begin
					nxt.ln[i].q[SH] = 1'b0;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[t+1].vld <= 1'b0;
			end else begin
				div_s[t+1] <= nxt;
			end
		end
	end

	// sign, saturation and zero axis forcing
	div_t               dl;
	logic signed [15:0] v_nxt [0:2];
	always_comb begin
		dl = div_s[QBITS];
		for (int i = 0; i < 3; i++) begin
			if (dl.zero) begin
				v_nxt[i] = '0;
			end else if (dl.ln[i].neg) begin
				if (dl.ln[i].ovf || dl.ln[i].q > 17'd32768) begin
					v_nxt[i] = -16'sd32768;
				end else begin
					v_nxt[i] = 16'(-$signed({1'b0, dl.ln[i].q}));
				end
			end else begin
				if (dl.ln[i].ovf || dl.ln[i].q > 17'd32767) begin
					v_nxt[i] = 16'sd32767;
				end else begin
					v_nxt[i] = 16'(dl.ln[i].q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dl.vld;
		end
	end
	always_ff @(posedge clk) begin
		quat_x    <= v_nxt[0];
		quat_y    <= v_nxt[1];
		quat_z    <= v_nxt[2];
		quat_w    <= dl.w;
		axis_zero <= dl.zero;
	end

endmodule

// ===== sim/tb_axis_angle_to_quaternion_core.sv =====
// testbench for the axis-angle to quaternion core: self-checking against a built-in predictor
module tb_axis_angle_to_quaternion_core;

	import aaq_pkg::*;

	localparam int STEPS    = 16;
	localparam int LATENCY  = 53;
	localparam int WDOG_MAX = 2000;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] ang;
	} axis_item_t;

	typedef struct {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic               zero;
	} quat_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] axis_x, axis_y, axis_z, angle;
	logic               done;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic               axis_zero;

	axis_item_t pending_items[$];
	quat_t      expected_quats[$];
	int         mismatches;
	int         idle_pct;
	bit         hold_off;
	int         wdog;

	axis_angle_to_quaternion_core #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
		.done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.quat_w(quat_w), .axis_zero(axis_zero)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// arctangent of 2^-i in Q2.30
	function automatic longint arctan_q30(int i);
		longint t[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127, 63, 31, 15, 7, 3, 1};
		return t[i];
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// cordic half-angle rotation, then normalized axis scaled by the sine
	function automatic quat_t rotation_quat(axis_item_t it);
		quat_t q;
		longint z, cx, cy, dx, dy, ax, ay, az, r;
		longint unsigned len2;
		bit flip;
		int n;
		ax = it.ax;
		ay = it.ay;
		az = it.az;
		z = longint'(it.ang) * 131072;
		flip = 0;
		cx = 64'sd652032874;
		cy = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		n = (STEPS > 30) ? 30 : STEPS;
		for (int i = 0; i < n; i++) begin
			dx = shr_floor(cy, i);
			dy = shr_floor(cx, i);
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= arctan_q30(i);
			end else begin
				cx += dx;
				cy -= dy;
				z += arctan_q30(i);
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		q.qw = clamp16(round_div(cx, 65536));
		len2 = ax * ax + ay * ay + az * az;
		if (len2 == 0) begin
			q.qx = 0;
			q.qy = 0;
			q.qz = 0;
			q.zero = 1'b1;
		end else begin
			r = isqrt(len2 << 32);
			q.qx = clamp16(round_div(ax * cy, r));
			q.qy = clamp16(round_div(ay * cy, r));
			q.qz = clamp16(round_div(az * cy, r));
			q.zero = 1'b0;
		end
		return q;
	endfunction

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return $signed(16'($urandom_range(0, 31)) - 16'sd16);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_item(logic signed [15:0] x, y, z, a);
		axis_item_t it;
		it.ax = x;
		it.ay = y;
		it.az = z;
		it.ang = a;
		pending_items.push_back(it);
	endtask

	// driver: the head of the queue is on the ports while start is high,
	// and leaves the queue at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) void'(pending_items.pop_front());
			if (!start || !busy) begin
				// take the next item unless idling or held off
				if (!hold_off && pending_items.size() > 0 &&
						($urandom_range(0, 99) >= idle_pct)) begin
					start  <= 1'b1;
					axis_x <= pending_items[0].ax;
					axis_y <= pending_items[0].ay;
					axis_z <= pending_items[0].az;
					angle  <= pending_items[0].ang;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// predict at acceptance
	always @(posedge clk) begin
		axis_item_t cur;
		if (arst_n && start && !busy) begin
			cur.ax = axis_x;
			cur.ay = axis_y;
			cur.az = axis_z;
			cur.ang = angle;
			expected_quats.push_back(rotation_quat(cur));
		end
	end

	// monitor: every strobe is checked against the oldest expectation
	always @(posedge clk) begin
		quat_t e;
		if (arst_n && done) begin
			if (expected_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d w=%0d zero=%0b",
						quat_x, quat_y, quat_z, quat_w, axis_zero);
			end else begin
				e = expected_quats.pop_front();
				if (e.qx !== quat_x || e.qy !== quat_y || e.qz !== quat_z ||
						e.qw !== quat_w || e.zero !== axis_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x=%0d y=%0d z=%0d w=%0d zero=%0b act x=%0d y=%0d z=%0d w=%0d zero=%0b",
							e.qx, e.qy, e.qz, e.qw, e.zero,
							quat_x, quat_y, quat_z, quat_w, axis_zero);
				end
			end
		end
	end

	// watchdog on cycles with no accepted item or result
	always @(posedge clk) begin
		if ((start && !busy) || done) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		axis_x = 0;
		axis_y = 0;
		axis_z = 0;
		angle = 0;
		mismatches = 0;
		idle_pct = 0;
		hold_off = 0;
		wdog = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero axis, angles around the half-pi folds
		add_item(0, 0, 0, 0);
		add_item(0, 0, 0, 16'sh7fff);
		add_item(0, 0, 0, 16'sh8000);
		add_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		add_item(16'sh7fff, 0, 0, 6434);
		add_item(0, 16'sh8000, 0, 6435);
		add_item(0, 0, 1, 12868);
		add_item(1, 0, 0, -12868);
		add_item(-1, -1, -1, 12869);
		add_item(0, 0, 16'sh8000, -12869);
		add_item(8192, 0, 0, 4096);
		add_item(0, 8192, 0, -4096);
		add_item(1, 1, 1, 1);
		add_item(-1, 0, 1, -1);
		add_item(16'sh7fff, 16'sh8000, 0, 25736);
		add_item(1, 0, 0, 25735);
		add_item(0, 1, 0, -25736);

		// random phases alternate no idling and sender idling; the receiver cannot stall
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 60 : (ph == 3) ? 38 : 0;
			for (int n = 0; n < 100; n++)
				add_item(rand_field(), rand_field(), rand_field(), rand_field());
			while (pending_items.size() != 0) @(posedge clk);
			if (ph == 1) begin
				// pause until everything has drained
				hold_off = 1;
				while (expected_quats.size() != 0) @(posedge clk);
				@(posedge clk);
				hold_off = 0;
			end
		end
		while (pending_items.size() != 0 || start) @(posedge clk);
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
